// ===== rtl/core/aicd_pkg.sv =====
// types and constants shared by the instruction class decoder
package aicd_pkg;

  typedef enum logic [3:0] {
    CLS_MUL      = 4'd0,
    CLS_MUL_LONG = 4'd1,
    CLS_BX       = 4'd2,
    CLS_SWAP     = 4'd3,
    CLS_HW_REG   = 4'd4,
    CLS_HW_IMM   = 4'd5,
    CLS_SIGNED   = 4'd6,
    CLS_DATA     = 4'd7,
    CLS_SINGLE   = 4'd8,
    CLS_UNDEF    = 4'd9,
    CLS_BLOCK    = 4'd10,
    CLS_BRANCH   = 4'd11,
    CLS_CP_XFER  = 4'd12,
    CLS_CP_OP    = 4'd13,
    CLS_CP_REG   = 4'd14,
    CLS_SWI      = 4'd15
  } instr_class_t;

  localparam logic [27:0] BX_MASK   = 28'hFFFFFF0;
  localparam logic [27:0] BX_CODE   = 28'h12FFF10;
  localparam logic [27:0] MUL_MASK  = 28'h10000F0;
  localparam logic [27:0] MUL_CODE  = 28'h0000090;
  localparam logic [27:0] SWP_CODE  = 28'h1000090;
  localparam logic [27:0] HW_MASK   = 28'h04000F0;
  localparam logic [27:0] HWR_CODE  = 28'h00000B0;
  localparam logic [27:0] HWI_CODE  = 28'h04000B0;
  localparam logic [27:0] SGN_MASK  = 28'h00000D0;
  localparam logic [27:0] UND_MASK  = 28'h2000010;
  localparam logic [31:0] BR_ADDEND = 32'd8;

  localparam int unsigned IN_W  = 64;
  localparam int unsigned OUT_W = 96;

  typedef struct packed {
    instr_class_t instr_class;
    logic [3:0]   cond_code;
    logic [3:0]   reg_hi;
    logic [3:0]   reg_mid;
    logic [3:0]   reg_shift;
    logic [3:0]   reg_low;
    logic [1:0]   shift_kind;
    logic [3:0]   alu_op;
    logic [5:0]   ctrl_bits;
    logic [31:0]  imm_value;
    logic [31:0]  branch_target;
  } dec_t;

endpackage

// ===== rtl/core/aicd_decode.sv =====
// combinational class decode, field extraction, immediate and branch target
module aicd_decode (
  input  logic [31:0]        instr_word,
  input  logic [31:0]        fetch_addr,
  output aicd_pkg::dec_t     dec
);
  import aicd_pkg::*;

  logic [27:0]  op;
  instr_class_t cls;
  logic [31:0]  split;
  logic [31:0]  rot;
  logic [63:0]  rot_wide;
  logic [5:0]   rot_amt;
  logic [31:0]  shamt;
  logic [31:0]  br_off;
  logic [31:0]  imm;
  logic [31:0]  target;

  assign op = instr_word[27:0];

  always_comb begin
    case (op[27:26])
      2'd0: begin
        if (op[25])                             cls = CLS_DATA;
        else if ((op & BX_MASK) == BX_CODE)     cls = CLS_BX;
        else if ((op & MUL_MASK) == MUL_CODE)   cls = op[23] ? CLS_MUL_LONG : CLS_MUL;
        else if ((op & MUL_MASK) == SWP_CODE)   cls = CLS_SWAP;
        else if ((op & HW_MASK) == HWR_CODE)    cls = CLS_HW_REG;
        else if ((op & HW_MASK) == HWI_CODE)    cls = CLS_HW_IMM;
        else if ((op & SGN_MASK) == SGN_MASK)   cls = CLS_SIGNED;
        else                                    cls = CLS_DATA;
      end
      2'd1: begin
        cls = ((op & UND_MASK) == UND_MASK) ? CLS_UNDEF : CLS_SINGLE;
      end
      2'd2: begin
        cls = op[25] ? CLS_BRANCH : CLS_BLOCK;
      end
      default: begin
        if (op[25]) begin
          if (op[24])     cls = CLS_SWI;
          else if (op[4]) cls = CLS_CP_REG;
          else            cls = CLS_CP_OP;
        end else begin
          cls = CLS_CP_XFER;
        end
      end
    endcase
  end

  // rotate right by twice the rotate field; zero rotation falls out as the plain byte
  assign rot_amt  = {1'b0, instr_word[11:8], 1'b0};
  assign rot_wide = {24'd0, instr_word[7:0], 24'd0, instr_word[7:0]} >> rot_amt;
  assign rot      = rot_wide[31:0];

  assign split  = {24'd0, instr_word[11:8], instr_word[3:0]};
  assign shamt  = {27'd0, instr_word[11:7]};
  assign br_off = {{6{instr_word[23]}}, instr_word[23:0], 2'b00};

  always_comb begin
    imm    = 32'd0;
    target = 32'd0;
    case (cls)
      CLS_HW_IMM: imm = split;
      CLS_SIGNED: imm = instr_word[22] ? split : 32'd0;
      CLS_DATA: begin
        if (instr_word[25])     imm = rot;
        else if (!instr_word[4]) imm = shamt;
      end
      CLS_SINGLE: imm = instr_word[25] ? shamt : {20'd0, instr_word[11:0]};
      CLS_BLOCK:  imm = {16'd0, instr_word[15:0]};
      CLS_BRANCH: target = fetch_addr + BR_ADDEND + br_off;
      CLS_SWI:    imm = {8'd0, instr_word[23:0]};
      default: begin
        imm    = 32'd0;
        target = 32'd0;
      end
    endcase
  end

  always_comb begin
    dec.instr_class   = cls;
    dec.cond_code     = instr_word[31:28];
    dec.reg_hi        = instr_word[19:16];
    dec.reg_mid       = instr_word[15:12];
    dec.reg_shift     = instr_word[11:8];
    dec.reg_low       = instr_word[3:0];
    dec.shift_kind    = instr_word[6:5];
    dec.alu_op        = instr_word[24:21];
    dec.ctrl_bits     = instr_word[25:20];
    dec.imm_value     = imm;
    dec.branch_target = target;
  end

endmodule

// ===== rtl/core/arm32_instruction_class_decoder.sv =====
// top level: input register, class decode and result register
// Decodes one 32-bit ARM instruction word per cycle. An accepted word is held in
// the input register while the decode logic works on it, and its result is loaded
// into the output register, which drives out_tvalid. Both registers advance
// whenever the output register is empty or being drained, giving a sustained
// rate of one word per cycle; the only limit is downstream back-pressure.
module arm32_instruction_class_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [aicd_pkg::IN_W-1:0]   in_tdata,   // instr_word, fetch_addr
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [aicd_pkg::OUT_W-1:0]  out_tdata,  // cond_code, reg_hi, reg_mid, reg_shift,
                                                  // reg_low, shift_kind, alu_op, ctrl_bits,
                                                  // imm_value, branch_target
  output logic [3:0]                  out_tuser   // instr_class
);
  import aicd_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [31:0] word_r, addr_r;
  logic        out_vld_r, out_vld_nxt;
  dec_t        res_r;
  dec_t        dec;
  logic        adv;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;

  aicd_decode u_decode (
    .instr_word (word_r),
    .fetch_addr (addr_r),
    .dec        (dec)
  );

  always_comb begin
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = in_vld_r;
    end
    if (in_tready) begin
      in_vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      word_r <= in_tdata[31:0];
      addr_r <= in_tdata[63:32];
    end
    if (adv && in_vld_r) begin
      res_r <= dec;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.instr_class;
  assign out_tdata  = {res_r.branch_target, res_r.imm_value, res_r.ctrl_bits,
                       res_r.alu_op, res_r.shift_kind, res_r.reg_low,
                       res_r.reg_shift, res_r.reg_mid, res_r.reg_hi,
                       res_r.cond_code};

endmodule
